>>> design/fpmd_pkg.sv
// Package with constants and types for the frame pacing median deadline core.
`default_nettype none
package fpmd_pkg;
   localparam int unsigned WindowDefault = 15;
   localparam logic [31:0] TickFreqReset = 32'd10000000;
   localparam logic [63:0] NsPerS = 64'd1000000000;
   localparam logic [28:0] GapLimitNs = 29'd500000000;
   localparam logic [23:0] RenderMin = 24'd1000;
   localparam logic [23:0] RenderMax = 24'd1000000;
   localparam logic [7:0] MaxIndex = 8'd5;
   localparam logic [63:0] GapSpan = 64'h0000_0001_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP_MUL,
      ST_DIV,
      ST_GAP_CHECK,
      ST_SORT,
      ST_DL_PER,
      ST_DL_REND,
      ST_DL_MUL,
      ST_DL_STEP,
      ST_DL_WAIT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> design/frame_pacing_median_deadline_core.sv
// Top level of the frame pacing median deadline core with its shared multiplier and divider.
// A frame transaction runs one 64-step divide and, when its gap enters the window, then a rank
// count of one ring pair per cycle.
// A deadline transaction runs three 64-step divides, or skips them when rejected.
// Throughput is one transaction at a time; the next is accepted once the result is taken.
// Reset is synchronous and active high; it clears the ring, median and last tick, freq 10 MHz.
`default_nettype none
module frame_pacing_median_deadline_core
   import fpmd_pkg::*;
#(
   parameter int unsigned WINDOW = WindowDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [31:0]         csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_action,
   input  wire logic [62:0]         req_timestamp,
   input  wire logic signed [63:0]  req_deadline_in,
   input  wire logic signed [63:0]  req_total_interval,
   input  wire logic [7:0]          req_frame_index,
   input  wire logic [7:0]          req_frame_total,
   input  wire logic                req_render_known,
   input  wire logic [23:0]         req_render_estimate,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [28:0]              rsp_median_gap_ns,
   output logic signed [63:0]       rsp_deadline_out,
   output logic [62:0]              rsp_wait_until,
   output logic                     rsp_wait_valid,
   output logic                     rsp_status
);
   localparam int unsigned PW = $clog2(WINDOW + 1);
   localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [31:0] freq_ff;
   logic [28:0] ring_ff [WINDOW];
   logic [IW-1:0] wpos_ff;
   logic [PW-1:0] fill_ff;
   logic [62:0] last_ff;
   logic [28:0] median_ff;

   logic [62:0] ts_ff;
   logic [63:0] dl_ff, iv_ff;
   logic [7:0]  fi_ff, ft_ff;
   logic        rk_ff;
   logic [23:0] re_ff;

   // Shared multiplier operands and divider.
   logic [31:0] ma_ff, mb_ff;
   logic [63:0] prod;
   logic [63:0] quo_ff, rem_ff, dvs_ff;
   logic [6:0]  cnt_ff;
   logic [64:0] trial;
   logic [63:0] per_ff;
   logic [IW-1:0] si_ff, sj_ff;
   logic [PW-1:0] rank_ff;
   logic        found_ff;

   logic        rsp_valid_ff;
   logic [28:0] o_med_ff;
   logic [63:0] o_dl_ff;
   logic [62:0] o_wait_ff;
   logic        o_wv_ff, o_st_ff;

   logic [63:0] gap;
   logic [23:0] rclamp;
   logic        dl_ok;
   logic        gap_take;
   logic        busy;

   assign busy = (state_ff != ST_IDLE);
   assign req_ready = !busy && !(rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_median_gap_ns = o_med_ff;
   assign rsp_deadline_out = o_dl_ff;
   assign rsp_wait_until = o_wait_ff;
   assign rsp_wait_valid = o_wv_ff;
   assign rsp_status = o_st_ff;

   assign prod = ma_ff * mb_ff;
   assign gap = {1'b0, ts_ff} - {1'b0, last_ff};
   assign trial = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
   assign rclamp = (re_ff < RenderMin) ? RenderMin : ((re_ff > RenderMax) ? RenderMax : re_ff);
   assign dl_ok = (fi_ff >= 8'd1) && (fi_ff <= MaxIndex) && (ft_ff >= 8'd2)
                  && !iv_ff[63] && (iv_ff != 64'd0);
   assign gap_take = last_ff != 63'd0 && freq_ff != 32'd0 && !gap[63] && gap != 64'd0
                     && gap < GapSpan && quo_ff != 64'd0 && quo_ff < {35'd0, GapLimitNs};

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      case (state_ff)
         ST_IDLE: if (req_valid && req_ready) state_in = req_action ? ST_DL_PER : ST_GAP_MUL;
         ST_GAP_MUL: begin
            state_in = ST_DIV;
            ret_in = ST_GAP_CHECK;
         end
         ST_DIV: if (cnt_ff == 7'd63) state_in = ret_ff;
         ST_GAP_CHECK: state_in = gap_take ? ST_SORT : ST_DONE;
         ST_SORT: if (found_ff) state_in = ST_DONE;
         ST_DL_PER: begin
            state_in = dl_ok ? ST_DIV : ST_DONE;
            ret_in = ST_DL_REND;
         end
         ST_DL_REND: begin
            state_in = ST_DIV;
            ret_in = ST_DL_MUL;
         end
         ST_DL_MUL: state_in = ST_DL_STEP;
         ST_DL_STEP: begin
            state_in = ST_DIV;
            ret_in = ST_DL_WAIT;
         end
         ST_DL_WAIT: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         freq_ff <= TickFreqReset;
         wpos_ff <= '0;
         fill_ff <= '0;
         last_ff <= '0;
         median_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < WINDOW; k++) ring_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         if (csr_write_enable) freq_ff <= csr_write_data;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               ts_ff <= req_timestamp;
               dl_ff <= req_deadline_in;
               iv_ff <= req_total_interval;
               fi_ff <= req_frame_index;
               ft_ff <= req_frame_total;
               rk_ff <= req_render_known;
               re_ff <= req_render_estimate;
               o_dl_ff <= '0;
               o_wait_ff <= '0;
               o_wv_ff <= 1'b0;
               o_st_ff <= 1'b1;
               ma_ff <= req_timestamp[31:0] - last_ff[31:0];
               mb_ff <= NsPerS[31:0];
            end
            ST_GAP_MUL: begin
               quo_ff <= prod;
               rem_ff <= '0;
               dvs_ff <= {32'd0, freq_ff};
               cnt_ff <= '0;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (!trial[64]) begin
                  rem_ff <= trial[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[62:0], quo_ff[63]};
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
            end
            ST_GAP_CHECK: begin
               last_ff <= ts_ff;
               if (gap_take) begin
                  ring_ff[wpos_ff] <= quo_ff[28:0];
                  wpos_ff <= (wpos_ff == IW'(WINDOW - 1)) ? '0 : wpos_ff + 1'b1;
                  if (fill_ff < PW'(WINDOW)) fill_ff <= fill_ff + 1'b1;
                  o_st_ff <= 1'b0;
                  si_ff <= '0;
                  sj_ff <= '0;
                  rank_ff <= '0;
                  found_ff <= 1'b0;
               end
            end
            ST_SORT: if (!found_ff) begin
               // Element i is the median when its stable rank equals fill/2.
               if ((ring_ff[sj_ff] < ring_ff[si_ff])
                   || (ring_ff[sj_ff] == ring_ff[si_ff] && sj_ff < si_ff)) begin
                  rank_ff <= rank_ff + 1'b1;
               end
               if (PW'(sj_ff) == PW'(fill_ff - 1'b1)) begin
                  if (((ring_ff[sj_ff] < ring_ff[si_ff])
                       || (ring_ff[sj_ff] == ring_ff[si_ff] && sj_ff < si_ff)
                       ? rank_ff + 1'b1 : rank_ff) == (fill_ff >> 1)) begin
                     median_ff <= ring_ff[si_ff];
                     found_ff <= 1'b1;
                  end
                  si_ff <= si_ff + 1'b1;
                  sj_ff <= '0;
                  rank_ff <= '0;
               end else begin
                  sj_ff <= sj_ff + 1'b1;
               end
            end
            ST_DL_PER: begin
               o_dl_ff <= dl_ff;
               quo_ff <= iv_ff;
               rem_ff <= '0;
               dvs_ff <= {56'd0, ft_ff};
               cnt_ff <= '0;
            end
            ST_DL_REND: begin
               per_ff <= quo_ff;
               quo_ff <= {40'd0, rclamp};
               rem_ff <= '0;
               cnt_ff <= '0;
            end
            ST_DL_MUL: begin
               o_st_ff <= 1'b0;
               o_dl_ff <= dl_ff + {56'd0, fi_ff}
                          * (per_ff - ((rk_ff && quo_ff < per_ff) ? quo_ff : 64'd0));
               ma_ff <= {3'd0, median_ff};
               mb_ff <= freq_ff;
            end
            ST_DL_STEP: begin
               quo_ff <= prod;
               rem_ff <= '0;
               dvs_ff <= NsPerS * {56'd0, ft_ff};
               cnt_ff <= '0;
            end
            ST_DL_WAIT: begin
               if (last_ff != 63'd0 && freq_ff != 32'd0 && median_ff != 29'd0) begin
                  o_wait_ff <= last_ff + 63'(quo_ff * {56'd0, fi_ff});
                  o_wv_ff <= 1'b1;
               end
            end
            ST_DONE: begin
               o_med_ff <= median_ff;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
